// ===== hw/rtl/oriented_box_overlap_test_defines.svh =====
// Assertion macros shared by the oriented box overlap test RTL.
`ifndef ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define OBOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define OBOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/obot_pkg.sv =====
// Shared types, constants and the sine/cosine table generator.
package obot_pkg;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // Taylor term divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine.
  localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};
  localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                          64'd90, 64'd132, 64'd182, 64'd240};

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  // Clamp a Q2.30 value to [0, 1] and round half up to tfb fraction bits.
  function automatic logic [31:0] trig_frac(input logic signed [63:0] q30,
                                            input int unsigned tfb);
    logic [63:0] v;
    int unsigned sh;
    sh = 30 - tfb;
    if (q30 < 0) v = 64'd0;
    else if (q30 > $signed(ONE_Q30)) v = ONE_Q30;
    else v = q30;
    if (sh != 0) v = (v + (64'd1 << (sh - 1))) >> sh;
    return v[31:0];
  endfunction

  // First-quadrant entry for r = 4k mod depth; returns {sin, cos}.
  function automatic logic [63:0] trig_entry(input int unsigned r,
                                             input int unsigned dlog,
                                             input int unsigned tfb);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] st;
    logic [63:0] ct;
    logic signed [63:0] ssum;
    logic signed [63:0] csum;
    t    = (PI_HALF_Q30 * 64'(r)) >> dlog;
    t2   = (t * t) >> 30;
    st   = t;
    ct   = ONE_Q30;
    ssum = $signed(t);
    csum = $signed(ONE_Q30);
    for (int n = 0; n < 8; n++) begin
      st = ((st * t2) >> 30) / SIN_DIV[n];
      ct = ((ct * t2) >> 30) / COS_DIV[n];
      if ((n % 2) == 0) begin
        ssum = ssum - $signed(st);
        csum = csum - $signed(ct);
      end else begin
        ssum = ssum + $signed(st);
        csum = csum + $signed(ct);
      end
    end
    return {trig_frac(ssum, tfb), trig_frac(csum, tfb)};
  endfunction

endpackage

// ===== hw/rtl/obot_trig_rom.sv =====
// Quarter-wave sine/cosine ROM with two registered read ports.
module obot_trig_rom #(
  parameter int unsigned DLOG = 10,
  parameter int unsigned TFB  = 15
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DLOG-3:0]   addr_a,
  input  logic [DLOG-3:0]   addr_b,
  output logic [2*TFB+1:0]  data_a,
  output logic [2*TFB+1:0]  data_b
);

  localparam int unsigned QDEPTH = 2 ** (DLOG - 2);

  logic [2*TFB+1:0] rom [QDEPTH];
  logic [2*TFB+1:0] data_a_r;
  logic [2*TFB+1:0] data_b_r;

  for (genvar i = 0; i < QDEPTH; i++) begin : g_rom
    localparam logic [63:0] ENTRY = obot_pkg::trig_entry(4 * i, DLOG, TFB);
    assign rom[i] = {ENTRY[32+TFB:32], ENTRY[TFB:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= rom[addr_a];
      data_b_r <= rom[addr_b];
    end
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

// ===== hw/rtl/obot_proj.sv =====
// Projection stages: axis products, then projected distances and axis dots.
module obot_proj #(
  parameter int unsigned TFB = 15
) (
  input  logic                    clk,
  input  logic                    en_mul,
  input  logic                    en_sum,
  input  logic signed [TFB+1:0]   ca,
  input  logic signed [TFB+1:0]   sa,
  input  logic signed [TFB+1:0]   cb,
  input  logic signed [TFB+1:0]   sb,
  input  logic signed [32:0]      dx,
  input  logic signed [32:0]      dy,
  input  logic [63:0]             sizes,
  output logic [TFB+35:0]         proj_dist [4],
  output logic [TFB+2:0]          rna,
  output logic [TFB+2:0]          rnb,
  output logic [TFB+2:0]          rp,
  output logic [TFB+2:0]          rq,
  output logic [63:0]             sizes_out
);

  localparam int unsigned PW = TFB + 35;   // distance product width
  localparam int unsigned SW = TFB + 36;   // distance sum width
  localparam int unsigned TW = 2 * TFB + 5; // trig product/sum width

  logic signed [PW-1:0] pd_r [8];
  logic signed [TW-1:0] pt_r [8];
  logic [63:0]          sz_m_r;

  logic [SW-1:0]  dist_r [4];
  logic [TFB+2:0] rna_r, rnb_r, rp_r, rq_r;
  logic [63:0]    sz_s_r;

  logic signed [SW-1:0] dsum [4];
  logic signed [TW-1:0] tsum [4];
  logic [SW-1:0]        dmag [4];
  logic [TW-1:0]        tmag [4];
  logic [TW-1:0]        trnd [4];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      pd_r[0] <= dx * ca;
      pd_r[1] <= dy * sa;
      pd_r[2] <= dx * sa;
      pd_r[3] <= dy * ca;
      pd_r[4] <= dx * cb;
      pd_r[5] <= dy * sb;
      pd_r[6] <= dx * sb;
      pd_r[7] <= dy * cb;
      pt_r[0] <= ca * cb;
      pt_r[1] <= sa * sb;
      pt_r[2] <= sa * cb;
      pt_r[3] <= ca * sb;
      pt_r[4] <= ca * ca;
      pt_r[5] <= sa * sa;
      pt_r[6] <= cb * cb;
      pt_r[7] <= sb * sb;
      sz_m_r  <= sizes;
    end
  end

  always_comb begin
    dsum[0] = SW'(pd_r[0]) + SW'(pd_r[1]);
    dsum[1] = SW'(pd_r[3]) - SW'(pd_r[2]);
    dsum[2] = SW'(pd_r[4]) + SW'(pd_r[5]);
    dsum[3] = SW'(pd_r[7]) - SW'(pd_r[6]);
    tsum[0] = pt_r[4] + pt_r[5];   // first box self dot
    tsum[1] = pt_r[6] + pt_r[7];   // second box self dot
    tsum[2] = pt_r[0] + pt_r[1];   // cross dot, parallel pairs
    tsum[3] = pt_r[2] - pt_r[3];   // cross dot, perpendicular pairs
    for (int i = 0; i < 4; i++) begin
      dmag[i] = dsum[i][SW-1] ? SW'(-dsum[i]) : SW'(dsum[i]);
      tmag[i] = tsum[i][TW-1] ? TW'(-tsum[i]) : TW'(tsum[i]);
      trnd[i] = (tmag[i] + (TW'(1) << (TFB - 1))) >> TFB;
    end
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      for (int i = 0; i < 4; i++) dist_r[i] <= dmag[i];
      rna_r  <= trnd[0][TFB+2:0];
      rnb_r  <= trnd[1][TFB+2:0];
      rp_r   <= trnd[2][TFB+2:0];
      rq_r   <= trnd[3][TFB+2:0];
      sz_s_r <= sz_m_r;
    end
  end

  assign proj_dist = dist_r;
  assign rna       = rna_r;
  assign rnb       = rnb_r;
  assign rp        = rp_r;
  assign rq        = rq_r;
  assign sizes_out = sz_s_r;

endmodule

// ===== hw/rtl/obot_radius_cmp.sv =====
// Radius stages: half extent products, then radius sum against distance.
module obot_radius_cmp #(
  parameter int unsigned TFB = 15
) (
  input  logic              clk,
  input  logic              en_mul,
  input  logic              en_cmp,
  input  logic [TFB+35:0]   proj_dist [4],
  input  logic [TFB+2:0]    rna,
  input  logic [TFB+2:0]    rnb,
  input  logic [TFB+2:0]    rp,
  input  logic [TFB+2:0]    rq,
  input  logic [63:0]       sizes,
  output logic              overlapping
);

  localparam int unsigned MW = TFB + 19;
  localparam int unsigned CW = TFB + 36;

  logic [15:0]    ahw, ahh, bhw, bhh;
  logic [MW-1:0]  m_r [12];
  logic [CW-1:0]  dist_r [4];
  logic [CW-1:0]  rsum [4];
  logic           sep;
  logic           overlapping_r;

  assign ahw = sizes[63:48];
  assign ahh = sizes[47:32];
  assign bhw = sizes[31:16];
  assign bhh = sizes[15:0];

  always_ff @(posedge clk) begin
    if (en_mul) begin
      m_r[0]  <= ahw * rna;
      m_r[1]  <= bhw * rp;
      m_r[2]  <= bhh * rq;
      m_r[3]  <= ahh * rna;
      m_r[4]  <= bhw * rq;
      m_r[5]  <= bhh * rp;
      m_r[6]  <= ahw * rp;
      m_r[7]  <= ahh * rq;
      m_r[8]  <= bhw * rnb;
      m_r[9]  <= ahw * rq;
      m_r[10] <= ahh * rp;
      m_r[11] <= bhh * rnb;
      dist_r  <= proj_dist;
    end
  end

  // Sum both radii on each axis; separate if any distance exceeds it.
  always_comb begin
    rsum[0] = CW'(m_r[0]) + CW'(m_r[1]) + CW'(m_r[2]);
    rsum[1] = CW'(m_r[3]) + CW'(m_r[4]) + CW'(m_r[5]);
    rsum[2] = CW'(m_r[6]) + CW'(m_r[7]) + CW'(m_r[8]);
    rsum[3] = CW'(m_r[9]) + CW'(m_r[10]) + CW'(m_r[11]);
    sep = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (dist_r[i] > rsum[i]) sep = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_cmp) begin
      overlapping_r <= !sep;
    end
  end

  assign overlapping = overlapping_r;

endmodule

// ===== hw/rtl/oriented_box_overlap_test.sv =====
// Throughput: one box pair per cycle; each stage holds only when its successor is full.
// Stages: table read, quadrant map, axis multiply, projection sum, radius multiply, compare.
// Reset: synchronous active-low rst_n clears all stage valid bits; payload is not reset.
// Trig table: quarter-wave constant ROM of SINE_TABLE_DEPTH/4 entries, two read ports.
`include "oriented_box_overlap_test_defines.svh"

module oriented_box_overlap_test #(
  parameter int unsigned ANGLE_BITS       = 16,
  parameter int unsigned TRIG_FRAC_BITS   = 15,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_first_center_x,
  input  logic signed [31:0]  in_first_center_y,
  input  logic [15:0]         in_first_half_width,
  input  logic [15:0]         in_first_half_height,
  input  logic [15:0]         in_first_angle,
  input  logic signed [31:0]  in_second_center_x,
  input  logic signed [31:0]  in_second_center_y,
  input  logic [15:0]         in_second_half_width,
  input  logic [15:0]         in_second_half_height,
  input  logic [15:0]         in_second_angle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_overlapping
);

  localparam int unsigned T      = TRIG_FRAC_BITS;
  localparam int unsigned DLOG   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned NSTAGE = 6;

  // Stage valid bits and per-stage load enables (ready ripples backward).
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] ld;

  always_comb begin
    ld[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
    vld_nxt = vld_r;
    if (ld[0]) vld_nxt[0] = in_valid;
    for (int i = 1; i < NSTAGE; i++) begin
      if (ld[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[NSTAGE-1];

  // Table index: scale the binary angle to the table depth, dropping or zero-padding low bits.
  logic [ANGLE_BITS-1:0] ang_a, ang_b;
  logic [DLOG-1:0]       k_a, k_b;

  assign ang_a = ANGLE_BITS'(in_first_angle);
  assign ang_b = ANGLE_BITS'(in_second_angle);

  if (DLOG <= ANGLE_BITS) begin : g_idx_shr
    assign k_a = ang_a[ANGLE_BITS-1 -: DLOG];
    assign k_b = ang_b[ANGLE_BITS-1 -: DLOG];
  end else begin : g_idx_shl
    assign k_a = {ang_a, (DLOG - ANGLE_BITS)'(0)};
    assign k_b = {ang_b, (DLOG - ANGLE_BITS)'(0)};
  end

  // Stage 1: table read, center difference, hold sizes and quadrants.
  logic [2*T+1:0]    rd_a, rd_b;
  logic [1:0]        qa_r, qb_r;
  logic signed [32:0] dx1_r, dy1_r;
  logic [63:0]       sz1_r;

  obot_trig_rom #(.DLOG(DLOG), .TFB(T)) u_rom (
    .clk    (clk),
    .en     (ld[0]),
    .addr_a (k_a[DLOG-3:0]),
    .addr_b (k_b[DLOG-3:0]),
    .data_a (rd_a),
    .data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      qa_r  <= k_a[DLOG-1:DLOG-2];
      qb_r  <= k_b[DLOG-1:DLOG-2];
      dx1_r <= 33'(in_second_center_x) - 33'(in_first_center_x);
      dy1_r <= 33'(in_second_center_y) - 33'(in_first_center_y);
      sz1_r <= {in_first_half_width, in_first_half_height,
                in_second_half_width, in_second_half_height};
    end
  end

  // Stage 2: rotate the first-quadrant pair into the angle's quadrant.
  function automatic logic [2*T+3:0] quad_map(input logic [2*T+1:0] ent,
                                               input logic [1:0] q);
    logic signed [T+1:0] sv;
    logic signed [T+1:0] cv;
    logic signed [T+1:0] s;
    logic signed [T+1:0] c;
    sv = $signed({1'b0, ent[2*T+1:T+1]});
    cv = $signed({1'b0, ent[T:0]});
    case (obot_pkg::quad_t'(q))
      obot_pkg::QUAD_0: begin s = sv;  c = cv;  end
      obot_pkg::QUAD_1: begin s = cv;  c = -sv; end
      obot_pkg::QUAD_2: begin s = -sv; c = -cv; end
      obot_pkg::QUAD_3: begin s = -cv; c = sv;  end
      default:          begin s = sv;  c = cv;  end
    endcase
    return {s, c};
  endfunction

  logic [2*T+3:0]     ax_a, ax_b;
  logic signed [T+1:0] ca_r, sa_r, cb_r, sb_r;
  logic signed [32:0] dx2_r, dy2_r;
  logic [63:0]        sz2_r;

  assign ax_a = quad_map(rd_a, qa_r);
  assign ax_b = quad_map(rd_b, qb_r);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sa_r  <= $signed(ax_a[2*T+3:T+2]);
      ca_r  <= $signed(ax_a[T+1:0]);
      sb_r  <= $signed(ax_b[2*T+3:T+2]);
      cb_r  <= $signed(ax_b[T+1:0]);
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      sz2_r <= sz1_r;
    end
  end

  // Stages 3 and 4: projected center distance and rounded axis dots.
  logic [T+35:0] proj_dist [4];
  logic [T+2:0]  rna, rnb, rp, rq;
  logic [63:0]   sz4;

  obot_proj #(.TFB(T)) u_proj (
    .clk       (clk),
    .en_mul    (ld[2]),
    .en_sum    (ld[3]),
    .ca        (ca_r),
    .sa        (sa_r),
    .cb        (cb_r),
    .sb        (sb_r),
    .dx        (dx2_r),
    .dy        (dy2_r),
    .sizes     (sz2_r),
    .proj_dist (proj_dist),
    .rna       (rna),
    .rnb       (rnb),
    .rp        (rp),
    .rq        (rq),
    .sizes_out (sz4)
  );

  // Stages 5 and 6: radii per axis, then compare into the output word.
  obot_radius_cmp #(.TFB(T)) u_rcmp (
    .clk         (clk),
    .en_mul      (ld[4]),
    .en_cmp      (ld[5]),
    .proj_dist   (proj_dist),
    .rna         (rna),
    .rnb         (rnb),
    .rp          (rp),
    .rq          (rq),
    .sizes       (sz4),
    .overlapping (out_overlapping)
  );

  // A ready sink lets every stage advance.
  `OBOT_ASSERT_NOW(a_sink_ready_open, out_ready, in_ready, "in_ready low while out_ready high")
  // An empty pipeline always accepts.
  `OBOT_ASSERT_NOW(a_empty_accepts, vld_r == '0, in_ready, "empty pipeline not ready")
  // A word in stage 5 moves into an empty stage 6.
  `OBOT_ASSERT_NEXT(a_bubble_fill, vld_r[NSTAGE-2] && !vld_r[NSTAGE-1], out_valid,
                    "word lost between radius and compare stages")

endmodule

// ===== tb/oriented_box_overlap_test_tb.sv =====
// Testbench for the oriented box overlap test: streams box pairs, predicts overlap, checks results.
module oriented_box_overlap_test_tb;

  localparam int unsigned ANG_BITS  = 16;
  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned LATENCY   = 6;
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [15:0]        aw;
    logic [15:0]        ah;
    logic [15:0]        aang;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [15:0]        bw;
    logic [15:0]        bh;
    logic [15:0]        bang;
  } box_pair_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_first_center_x;
  logic signed [31:0] in_first_center_y;
  logic [15:0] in_first_half_width;
  logic [15:0] in_first_half_height;
  logic [15:0] in_first_angle;
  logic signed [31:0] in_second_center_x;
  logic signed [31:0] in_second_center_y;
  logic [15:0] in_second_half_width;
  logic [15:0] in_second_half_height;
  logic [15:0] in_second_angle;
  logic out_valid;
  logic out_ready;
  logic out_overlapping;

  oriented_box_overlap_test dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_center_x(in_first_center_x), .in_first_center_y(in_first_center_y),
    .in_first_half_width(in_first_half_width), .in_first_half_height(in_first_half_height),
    .in_first_angle(in_first_angle),
    .in_second_center_x(in_second_center_x), .in_second_center_y(in_second_center_y),
    .in_second_half_width(in_second_half_width),
    .in_second_half_height(in_second_half_height),
    .in_second_angle(in_second_angle),
    .out_valid(out_valid), .out_ready(out_ready), .out_overlapping(out_overlapping)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Stimulus plumbing shared by the initial block, the driver and the monitor.
  box_pair_t pending_pairs[$];
  logic      expected_overlap[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit        stimulus_done = 0;
  int unsigned error_count = 0;
  int unsigned words_checked = 0;
  int unsigned overlap_seen = 0;
  longint unsigned cycle_count = 0;

  function automatic longint q30_to_trig(input longint v);
    if (v < 0) v = 0;
    if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
    return (v + (64'sd1 <<< (30 - FRAC_BITS - 1))) >>> (30 - FRAC_BITS);
  endfunction

  // Sine/cosine of table entry k in QT, quadrant mapped.
  function automatic void unit_axis_of(input logic [15:0] angle,
                                       output longint s, output longint c);
    longint unsigned k, q, r, t, t2, st, ct;
    longint ssum, csum, sv, cv;
    k = (longint'(angle) * DEPTH) >> ANG_BITS;
    q = (4 * k) / DEPTH;
    r = 4 * k - q * DEPTH;
    t = (64'd1686629713 * r) / DEPTH;
    t2 = (t * t) >> 30;
    st = t;
    ct = 64'd1 << 30;
    ssum = t;
    csum = 64'd1 << 30;
    for (int n = 1; n <= 8; n++) begin
      st = ((st * t2) >> 30) / ((2 * n) * (2 * n + 1));
      ct = ((ct * t2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2) begin
        ssum -= st; csum -= ct;
      end else begin
        ssum += st; csum += ct;
      end
    end
    sv = q30_to_trig(ssum);
    cv = q30_to_trig(csum);
    case (obot_pkg::quad_t'(q[1:0]))
      obot_pkg::QUAD_0: begin s = sv;  c = cv;  end
      obot_pkg::QUAD_1: begin s = cv;  c = -sv; end
      obot_pkg::QUAD_2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endfunction

  function automatic longint unsigned abs_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned proj_mag(input longint px, py, qx, qy);
    return (abs_of(px * qx + py * qy) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

  // Separating axis test over both boxes' local axes; edge contact overlaps.
  function automatic logic boxes_overlap(input box_pair_t p);
    longint as, ac, bs, bc, dx, dy;
    longint lx[4], ly[4];
    longint unsigned axis_dist, ra, rb;
    logic apart;
    unit_axis_of(p.aang, as, ac);
    unit_axis_of(p.bang, bs, bc);
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    lx[0] = ac;  ly[0] = as;
    lx[1] = -as; ly[1] = ac;
    lx[2] = bc;  ly[2] = bs;
    lx[3] = -bs; ly[3] = bc;
    apart = 1'b0;
    for (int i = 0; i < 4; i++) begin
      axis_dist = abs_of(dx * lx[i] + dy * ly[i]);
      ra = p.aw * proj_mag(ac, as, lx[i], ly[i]) + p.ah * proj_mag(-as, ac, lx[i], ly[i]);
      rb = p.bw * proj_mag(bc, bs, lx[i], ly[i]) + p.bh * proj_mag(-bs, bc, lx[i], ly[i]);
      if (axis_dist > ra + rb) apart = 1'b1;
    end
    return !apart;
  endfunction

  function automatic box_pair_t random_pair(input int unsigned spread);
    box_pair_t p;
    p.ax = $urandom; p.ay = $urandom;
    p.aw = $urandom; p.ah = $urandom; p.aang = $urandom;
    p.bw = $urandom; p.bh = $urandom; p.bang = $urandom;
    if ($urandom_range(3) == 0) begin
      p.bx = $urandom; p.by = $urandom;
    end else begin
      // Keep the second box near the first so both outcomes show up.
      p.ax = $signed(p.ax) >>> 2; p.ay = $signed(p.ay) >>> 2;
      p.bx = p.ax + $signed(32'($urandom_range(2 * spread)) - spread);
      p.by = p.ay + $signed(32'($urandom_range(2 * spread)) - spread);
    end
    if ($urandom_range(3) == 0) begin
      p.aw = p.aw >> 8; p.ah = p.ah >> 8; p.bw = p.bw >> 8; p.bh = p.bh >> 8;
    end
    return p;
  endfunction

  // Driver: advance to the next pair after each accepted word, idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        box_pair_t p;
        p = pending_pairs.pop_front();
        in_valid <= 1'b1;
        in_first_center_x <= p.ax;  in_first_center_y <= p.ay;
        in_first_half_width <= p.aw; in_first_half_height <= p.ah;
        in_first_angle <= p.aang;
        in_second_center_x <= p.bx; in_second_center_y <= p.by;
        in_second_half_width <= p.bw; in_second_half_height <= p.bh;
        in_second_angle <= p.bang;
        expected_overlap.push_back(boxes_overlap(p));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_overlap.size() == 0) begin
          $error("unexpected result word, overlapping=%0b", out_overlapping);
          error_count++;
        end else begin
          logic want;
          want = expected_overlap.pop_front();
          words_checked++;
          overlap_seen += out_overlapping;
          if (out_overlapping !== want) begin
            $error("overlapping: expected %0b, actual %0b", want, out_overlapping);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold until the driver queue drains and all predictions are consumed.
  task automatic drain_all();
    wait (pending_pairs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_overlap.size() != 0) @(posedge clk);
  endtask

  initial begin
    box_pair_t p;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: same centres, points, edge contact, field extremes, angle wrap points.
    p = '0;
    pending_pairs.push_back(p);
    p.bx = 32'sd1; pending_pairs.push_back(p);
    p = '0; p.aw = 16'h0100; p.bw = 16'h0100; p.bx = 32'sh200; pending_pairs.push_back(p);
    p.bx = 32'sh201; pending_pairs.push_back(p);
    p.aang = 16'h4000; p.bang = 16'h8000; pending_pairs.push_back(p);
    p.aang = 16'hC000; p.bang = 16'h2000; pending_pairs.push_back(p);
    p.aang = 16'hFFFF; p.bang = 16'h003F; pending_pairs.push_back(p);
    p = '1; pending_pairs.push_back(p);
    p.ax = 32'sh7FFFFFFF; p.ay = 32'sh7FFFFFFF;
    p.bx = 32'sh80000000; p.by = 32'sh80000000; pending_pairs.push_back(p);
    p.aw = '0; p.ah = '0; p.bw = '0; p.bh = '0; pending_pairs.push_back(p);
    p = '1; p.ax = 32'sh80000000; p.bx = 32'sh7FFFFFFF; p.ay = '0; p.by = '0;
    pending_pairs.push_back(p);
    p = '0; p.aw = 16'hFFFF; p.ah = 16'hFFFF; p.bw = 16'hFFFF; p.bh = 16'hFFFF;
    p.aang = 16'h2000; p.bx = 32'sh01FFFE00; pending_pairs.push_back(p);
    for (int i = 0; i < 8; i++) begin
      p = '0; p.aw = 16'h0080 << i; p.bh = 16'h0100; p.aang = 16'(i * 16'h2000);
      p.bang = 16'(~(i * 16'h1111)); p.bx = 32'(i * 32'h180); pending_pairs.push_back(p);
    end
    drain_all();

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 27 : 0;
      recv_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 27 : 0;
      for (int i = 0; i < RANDOM_WORDS / 4; i++) begin
        pending_pairs.push_back(random_pair(32'h1 << $urandom_range(8, 26)));
        // Pause the sender once until the pipe is empty.
        if (ph == 0 && i == 100) drain_all();
      end
      drain_all();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    repeat (LATENCY * 4) @(posedge clk);
    $display("Checked %0d result words, %0d overlapping, across four idle/stall phases.",
             words_checked, overlap_seen);
    if (error_count == 0 && expected_overlap.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: end the run if the pipe hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/obot_pkg.sv
hw/rtl/obot_trig_rom.sv
hw/rtl/obot_proj.sv
hw/rtl/obot_radius_cmp.sv
hw/rtl/oriented_box_overlap_test.sv
tb/oriented_box_overlap_test_tb.sv
